FILE: sv/color_ramp_interpolator_defines.svh
// Assertion macros shared by the colour ramp modules.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef COLOR_RAMP_INTERPOLATOR_DEFINES_SVH
`define COLOR_RAMP_INTERPOLATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CRMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CRMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/crmp_pkg.sv
package crmp_pkg;

  localparam int MAX_STOPS   = 6;
  localparam int STOP_REGS   = 6;
  localparam int STOPS_LIMIT = (MAX_STOPS < STOP_REGS) ? MAX_STOPS : STOP_REGS;

  localparam int N_CHAN    = 3;
  localparam int VAL_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 3;
  localparam int QUO_W     = CHAN_W;
  localparam int DELTA_W   = CHAN_W + 1;
  localparam int REM_W     = VAL_W + QUO_W;
  localparam int DVS_W     = VAL_W + QUO_W - 1;
  localparam int PROD_W    = DELTA_W + VAL_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BASE    = 3'd1;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [VAL_W-1:0]  value;
  } stop_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  base;
    logic [DELTA_W-1:0] delta;
  } chan_sel_t;

  typedef struct packed {
    logic [VAL_W-1:0]        off;
    logic [VAL_W-1:0]        span;
    chan_sel_t [N_CHAN-1:0]  ch;
  } sel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] base;
    logic              neg;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } chan_div_t;

  typedef struct packed {
    logic [DVS_W-1:0]        dvs;
    chan_div_t [N_CHAN-1:0]  ch;
  } div_t;

  function automatic logic [CHAN_W-1:0] chan_of(stop_t s, int c);
    logic [CHAN_W-1:0] v;
    case (c)
      CH_RED:   v = s.red;
      CH_GREEN: v = s.green;
      default:  v = s.blue;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/crmp_cfg.sv
module crmp_cfg (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [crmp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [crmp_pkg::CFG_W-1:0]              cfg_data,
  output logic [crmp_pkg::CNT_W-1:0]              stops_in_use,
  output crmp_pkg::stop_t [crmp_pkg::STOP_REGS-1:0] stops
);
  import crmp_pkg::*;

  logic [CNT_W-1:0]          count_r;
  stop_t [STOP_REGS-1:0]     stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      stop_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_STOPS_IN_USE) begin
        count_r <= cfg_data[CNT_W-1:0];
      end
      for (int i = 0; i < STOP_REGS; i++) begin
        if (cfg_index == CFG_STOP_BASE + CFG_IDX_W'(i)) begin
          stop_r[i] <= cfg_data;
        end
      end
    end
  end

  assign stops_in_use = count_r;
  assign stops        = stop_r;

endmodule

FILE: sv/crmp_front.sv
`include "color_ramp_interpolator_defines.svh"

module crmp_front (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [crmp_pkg::VAL_W-1:0]         in_sample,
  input  logic [crmp_pkg::CNT_W-1:0]                stops_in_use,
  input  crmp_pkg::stop_t [crmp_pkg::STOP_REGS-1:0] stops,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output crmp_pkg::sel_t                            out_data
);
  import crmp_pkg::*;

  logic                     s1_valid_r;
  logic [VAL_W-1:0]         s1_sample_r;
  logic [STOP_REGS-1:0]     s1_ge_r;
  logic                     s1_le0_r;
  logic [STOP_REGS-1:0]     ge_nxt;
  logic                     le0_nxt;
  logic                     s1_ready;

  logic                     s2_valid_r;
  sel_t                     s2_data_r;
  sel_t                     s2_data_nxt;
  logic                     s2_ready;

  logic [CNT_W-1:0]         n_eff;
  logic [CNT_W-1:0]         n_m1;
  logic                     off_ok;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    for (int i = 0; i < STOP_REGS; i++) begin
      ge_nxt[i] = in_sample >= $signed(stops[i].value);
    end
    le0_nxt = in_sample <= $signed(stops[0].value);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_sample_r <= in_sample;
      s1_ge_r     <= ge_nxt;
      s1_le0_r    <= le0_nxt;
    end
  end

  assign n_eff = (stops_in_use > CNT_W'(STOPS_LIMIT)) ? CNT_W'(STOPS_LIMIT) : stops_in_use;
  assign n_m1  = n_eff - 1'b1;

  always_comb begin
    logic              last_ge;
    stop_t             last_stop;
    logic              found;
    logic [VAL_W:0]    diff_off;
    logic [VAL_W:0]    diff_span;
    last_ge     = 1'b0;
    last_stop   = '0;
    found       = 1'b0;
    diff_off    = '0;
    diff_span   = '0;
    s2_data_nxt = '0;
    s2_data_nxt.span = VAL_W'(1);
    for (int i = 0; i < STOP_REGS; i++) begin
      if (n_m1 == CNT_W'(i)) begin
        last_ge   = s1_ge_r[i];
        last_stop = stops[i];
      end
    end
    if (n_eff < CNT_W'(2)) begin
      s2_data_nxt.span = VAL_W'(1);
    end else if (s1_le0_r) begin
      for (int c = 0; c < N_CHAN; c++) begin
        s2_data_nxt.ch[c].base = chan_of(stops[0], c);
      end
    end else if (last_ge) begin
      for (int c = 0; c < N_CHAN; c++) begin
        s2_data_nxt.ch[c].base = chan_of(last_stop, c);
      end
    end else begin
      for (int i = 0; i < STOP_REGS - 1; i++) begin
        if (!found && (4'(i + 1) < {1'b0, n_eff}) && s1_ge_r[i] && !s1_ge_r[i+1]) begin
          found     = 1'b1;
          diff_off  = {s1_sample_r[VAL_W-1], s1_sample_r}
                    - {stops[i].value[VAL_W-1], stops[i].value};
          diff_span = {stops[i+1].value[VAL_W-1], stops[i+1].value}
                    - {stops[i].value[VAL_W-1], stops[i].value};
          s2_data_nxt.off  = diff_off[VAL_W-1:0];
          s2_data_nxt.span = diff_span[VAL_W-1:0];
          for (int c = 0; c < N_CHAN; c++) begin
            s2_data_nxt.ch[c].base  = chan_of(stops[i], c);
            s2_data_nxt.ch[c].delta = {1'b0, chan_of(stops[i+1], c)}
                                    - {1'b0, chan_of(stops[i], c)};
          end
        end
      end
      if (!found) begin
        for (int c = 0; c < N_CHAN; c++) begin
          s2_data_nxt.ch[c].base = chan_of(last_stop, c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

  // The offset into the chosen interval must lie strictly below its width.
  assign off_ok = s2_data_r.off < s2_data_r.span;

  `CRMP_ASSERT_NOW(front_off_in_span, s2_valid_r, off_ok, "interval offset not below span")

endmodule

FILE: sv/crmp_mul.sv
module crmp_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  crmp_pkg::sel_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output crmp_pkg::div_t  out_data
);
  import crmp_pkg::*;

  logic  valid_r;
  div_t  data_r;
  div_t  data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] mag;
    prod     = '0;
    mag      = '0;
    data_nxt = '0;
    data_nxt.dvs = {in_data.span, {(QUO_W-1){1'b0}}};
    for (int c = 0; c < N_CHAN; c++) begin
      prod = $signed(in_data.ch[c].delta) * $signed({1'b0, in_data.off});
      mag  = prod[PROD_W-1] ? -prod : prod;
      data_nxt.ch[c].base = in_data.ch[c].base;
      data_nxt.ch[c].neg  = prod[PROD_W-1];
      data_nxt.ch[c].rem  = mag[REM_W-1:0];
      data_nxt.ch[c].quo  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: sv/crmp_div_step.sv
`include "color_ramp_interpolator_defines.svh"

module crmp_div_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  crmp_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output crmp_pkg::div_t  out_data
);
  import crmp_pkg::*;

  logic  valid_r;
  div_t  data_r;
  div_t  data_nxt;
  logic  rem_bound_ok;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt     = in_data;
    data_nxt.dvs = in_data.dvs >> 1;
    for (int c = 0; c < N_CHAN; c++) begin
      if (in_data.ch[c].rem >= REM_W'(in_data.dvs)) begin
        data_nxt.ch[c].rem = in_data.ch[c].rem - REM_W'(in_data.dvs);
        data_nxt.ch[c].quo = {in_data.ch[c].quo[QUO_W-2:0], 1'b1};
      end else begin
        data_nxt.ch[c].quo = {in_data.ch[c].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // One quotient bit per step is enough only while the remainder stays
  // below twice the current shifted divisor.
  always_comb begin
    rem_bound_ok = 1'b1;
    for (int c = 0; c < N_CHAN; c++) begin
      if (in_data.ch[c].rem >= {in_data.dvs, 1'b0}) begin
        rem_bound_ok = 1'b0;
      end
    end
  end

  `CRMP_ASSERT_NOW(div_rem_bound, in_valid, rem_bound_ok, "divider remainder out of range")

endmodule

FILE: sv/color_ramp_interpolator.sv
// Colour ramp interpolator: maps signed Q16.8 samples to RGB pixels.
// Input channel: in_valid, in_stall, in_sample_value; a sample transfers
// on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid, out_stall, out_red, out_green, out_blue; a
// pixel transfers on a rising edge with out_valid high and out_stall low.
// Configuration: cfg_we, cfg_index, cfg_data; register 0 is the number of
// stops in use, registers 1 to 6 are the stops. Write only while idle.
// The sample passes twelve register stages (compare, select, multiply,
// eight restoring divide steps, output register); the first is loaded by
// the transferring edge. Throughput: one sample per clock cycle while
// out_stall is low; each of the twelve stages holds its own item, and
// the one-bit-per-stage divider sets the depth.
// When the receiver stalls, items keep moving into empty stages, so input
// is still taken until every stage is full; in_stall then rises.
// Reset (rst_n low at a rising edge) empties the pipeline and clears all
// configuration registers to zero, which gives black pixels.
`include "color_ramp_interpolator_defines.svh"

module color_ramp_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [crmp_pkg::VAL_W-1:0]   in_sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [crmp_pkg::CHAN_W-1:0]         out_red,
  output logic [crmp_pkg::CHAN_W-1:0]         out_green,
  output logic [crmp_pkg::CHAN_W-1:0]         out_blue,
  input  logic                                cfg_we,
  input  logic [crmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crmp_pkg::CFG_W-1:0]          cfg_data
);
  import crmp_pkg::*;

  logic [CNT_W-1:0]          stops_in_use;
  stop_t [STOP_REGS-1:0]     stops;

  logic                      front_ready;
  logic                      sel_valid;
  logic                      sel_ready;
  sel_t                      sel_data;

  logic                      div_valid [QUO_W+1];
  logic                      div_ready [QUO_W+1];
  div_t                      div_data  [QUO_W+1];

  logic                      out_valid_r;
  logic [CHAN_W-1:0]         red_r;
  logic [CHAN_W-1:0]         green_r;
  logic [CHAN_W-1:0]         blue_r;
  logic [CHAN_W-1:0]         chan_nxt [N_CHAN];
  logic                      out_ready;
  logic                      out_empties;

  crmp_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stops_in_use (stops_in_use),
    .stops        (stops)
  );

  crmp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (front_ready),
    .in_sample    (in_sample_value),
    .stops_in_use (stops_in_use),
    .stops        (stops),
    .out_valid    (sel_valid),
    .out_ready    (sel_ready),
    .out_data     (sel_data)
  );

  crmp_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_data   (sel_data),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    crmp_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[g]),
      .in_ready  (div_ready[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_ready (div_ready[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  assign out_ready         = !out_valid_r || !out_stall;
  assign div_ready[QUO_W]  = out_ready;

  always_comb begin
    for (int c = 0; c < N_CHAN; c++) begin
      if (div_data[QUO_W].ch[c].neg) begin
        chan_nxt[c] = div_data[QUO_W].ch[c].base - div_data[QUO_W].ch[c].quo;
      end else begin
        chan_nxt[c] = div_data[QUO_W].ch[c].base + div_data[QUO_W].ch[c].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= div_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (div_valid[QUO_W] && out_ready) begin
      red_r   <= chan_nxt[0];
      green_r <= chan_nxt[1];
      blue_r  <= chan_nxt[2];
    end
  end

  assign in_stall  = !front_ready;
  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  assign out_empties = out_valid_r && !out_stall && !div_valid[QUO_W];

  `CRMP_ASSERT_NOW(stall_needs_full_out, in_stall, out_valid_r && out_stall, "early input stall")
  `CRMP_ASSERT_NEXT(out_drains, out_empties, !out_valid_r, "output valid after drain")

endmodule

FILE: test/tb_color_ramp_interpolator.sv
`timescale 1ns / 1ps

module tb_color_ramp_interpolator;
  import crmp_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 120;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG     = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CHECK} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    logic [VAL_W-1:0]     sample;
    pixel_t               pix;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VAL_W-1:0]     in_sample_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [CNT_W-1:0] ramp_count = '0;
  stop_t            ramp_stop [STOP_REGS] = '{default: '0};
  pixel_t           pending_pixels [$];
  int               failures = 0;
  int               stalled_cycles = 0;
  bit               steady_feed = 1'b0;
  bit               hold_req = 1'b0;

  // Stop data is {blue, green, red, value}; pixels are written as RRGGBB.
  row_t plan [33] = '{
    '{ROW_CHECK,  '0,                   '0,                    24'h000000, 24'h000000},
    '{ROW_CHECK,  '0,                   '0,                    24'h800000, 24'h000000},
    '{ROW_CHECK,  '0,                   '0,                    24'h7FFFFF, 24'h000000},
    '{ROW_WRITE,  CFG_STOPS_IN_USE,     48'd1,                 '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE,        48'hFFFFFF_000000,     '0,         '0},
    '{ROW_CHECK,  '0,                   '0,                    24'h000005, 24'h000000},
    '{ROW_WRITE,  CFG_STOPS_IN_USE,     48'd2,                 '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE,        48'h302010_FFFF00,     '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE + 3'd1, 48'hFF00F0_000100,     '0,         '0},
    '{ROW_CHECK,  '0,                   '0,                    24'h800000, 24'h102030},
    '{ROW_CHECK,  '0,                   '0,                    24'hFFFF00, 24'h102030},
    '{ROW_CHECK,  '0,                   '0,                    24'h000100, 24'hF000FF},
    '{ROW_CHECK,  '0,                   '0,                    24'h7FFFFF, 24'hF000FF},
    '{ROW_SAMPLE, '0,                   '0,                    24'h000000, '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'h0000FF, '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'hFFFF01, '0},
    '{ROW_WRITE,  REG_UNUSED,           48'hFFFFFF_FFFFFF,     '0,         '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'h000080, '0},
    '{ROW_WRITE,  CFG_STOPS_IN_USE,     48'd7,                 '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE,        48'h000000_800000,     '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE + 3'd1, 48'h8000FF_000000,     '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE + 3'd2, 48'h00FF00_000000,     '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE + 3'd3, 48'h563412_0186A0,     '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE + 3'd4, 48'hFFFFFF_00C350,     '0,         '0},
    '{ROW_WRITE,  CFG_STOP_BASE + 3'd5, 48'h030201_7FFFFF,     '0,         '0},
    '{ROW_CHECK,  '0,                   '0,                    24'h800000, 24'h000000},
    '{ROW_CHECK,  '0,                   '0,                    24'h7FFFFF, 24'h010203},
    '{ROW_SAMPLE, '0,                   '0,                    24'hFFFFFF, '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'h000000, '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'h00EA60, '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'h0186A0, '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'h7FFFFE, '0},
    '{ROW_SAMPLE, '0,                   '0,                    24'h800001, '0}
  };

  color_ramp_interpolator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint stop_level(stop_t st);
    return longint'($signed(st.value));
  endfunction

  function automatic pixel_t stop_colour(stop_t st);
    return '{st.red, st.green, st.blue};
  endfunction

  function automatic int stops_active();
    return (int'(ramp_count) > STOPS_LIMIT) ? STOPS_LIMIT : int'(ramp_count);
  endfunction

  function automatic pixel_t ramp_pixel(logic [VAL_W-1:0] sample);
    int n;
    longint s, lo, hi, a, b;
    logic [CHAN_W-1:0] mix [3];
    n = stops_active();
    s = longint'($signed(sample));
    if (n < 2)
      return '0;
    if (s <= stop_level(ramp_stop[0]))
      return stop_colour(ramp_stop[0]);
    if (s >= stop_level(ramp_stop[n-1]))
      return stop_colour(ramp_stop[n-1]);
    for (int i = 0; i + 1 < n; i++) begin
      lo = stop_level(ramp_stop[i]);
      hi = stop_level(ramp_stop[i+1]);
      if (lo <= s && s < hi) begin
        for (int c = 0; c < 3; c++) begin
          a = longint'(ramp_stop[i][VAL_W + CHAN_W*c +: CHAN_W]);
          b = longint'(ramp_stop[i+1][VAL_W + CHAN_W*c +: CHAN_W]);
          mix[c] = CHAN_W'(a + ((b - a) * (s - lo)) / (hi - lo));
        end
        return '{mix[0], mix[1], mix[2]};
      end
    end
    return stop_colour(ramp_stop[n-1]);
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CHAN_W-1:0] channel_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // Most samples fall inside an interval or within one of a stop; the rest cover the full range.
  function automatic logic [VAL_W-1:0] pick_sample();
    int n, i, r;
    longint lo, hi, span;
    n = stops_active();
    r = $urandom_range(0, 99);
    if (n < 2 || r < 15)
      return VAL_W'($urandom());
    if (r < 30)
      return VAL_W'(stop_level(ramp_stop[$urandom_range(0, n - 1)])
                    + longint'($urandom_range(0, 2)) - 1);
    i = $urandom_range(0, n - 2);
    lo = stop_level(ramp_stop[i]);
    hi = stop_level(ramp_stop[i+1]);
    span = (hi > lo) ? hi - lo : lo - hi;
    return VAL_W'(((hi > lo) ? lo : hi) + longint'($urandom()) % (span + 1));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_STOPS_IN_USE)
      ramp_count = data[CNT_W-1:0];
    else if (idx >= CFG_STOP_BASE && int'(idx - CFG_STOP_BASE) < STOP_REGS)
      ramp_stop[idx - CFG_STOP_BASE] = data;
  endtask

  task automatic send_sample(logic [VAL_W-1:0] s, bit typed, pixel_t typed_pix);
    int k;
    in_valid <= 1'b1;
    in_sample_value <= s;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    pending_pixels.push_back(typed ? typed_pix : ramp_pixel(s));
    k = steady_feed ? 0 : idle_gap();
    if (k != 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int n_cfg, n, mode;
    longint lvl [STOP_REGS];
    longint tmp;
    bit writing;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    writing = 1'b0;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        if (!writing)
          drain();
        writing = 1'b1;
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        if (writing)
          cfg_we <= 1'b0;
        writing = 1'b0;
        send_sample(plan[r].sample, plan[r].kind == ROW_CHECK, plan[r].pix);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      steady_feed = (p < 2);
      n_cfg = $urandom_range(0, 9);
      n_cfg = (n_cfg == 0) ? $urandom_range(0, 1) : (n_cfg == 1) ? 7 : $urandom_range(2, 6);
      mode = $urandom_range(0, 3);
      if (p == 0) begin
        n_cfg = 6;
        mode = 1;
      end else if (p == 1) begin
        n_cfg = 7;
        mode = 3;
      end
      n = (n_cfg > STOPS_LIMIT) ? STOPS_LIMIT : n_cfg;
      for (int i = 0; i < STOP_REGS; i++) begin
        case (mode)
          1: lvl[i] = (i == 0) ? longint'($urandom_range(0, 2000000)) - 1000000
                               : lvl[i-1] + (($urandom_range(0, 3) == 0) ? 0
                                             : longint'($urandom_range(1, 600)));
          2: lvl[i] = longint'($urandom_range(0, 10000)) - 5000;
          default: lvl[i] = longint'($signed(VAL_W'($urandom())));
        endcase
      end
      if (mode == 0 || mode == 3) begin
        for (int i = 1; i < STOP_REGS; i++) begin
          for (int j = i; j > 0 && lvl[j-1] > lvl[j]; j--) begin
            tmp = lvl[j];
            lvl[j] = lvl[j-1];
            lvl[j-1] = tmp;
          end
        end
      end
      if (mode == 3 && n >= 2) begin
        lvl[0] = -longint'(1 << (VAL_W - 1));
        lvl[n-1] = longint'(1 << (VAL_W - 1)) - 1;
      end

      write_reg(CFG_STOPS_IN_USE, CFG_W'(n_cfg));
      for (int i = 0; i < STOP_REGS; i++)
        write_reg(CFG_STOP_BASE + CFG_IDX_W'(i),
                  {channel_byte(), channel_byte(), channel_byte(), lvl[i][VAL_W-1:0]});
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, CFG_W'({$urandom(), $urandom()}));
      cfg_we <= 1'b0;

      // The first phase feeds without gaps while the sink holds off, so the pipeline fills.
      if (p == 0)
        hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_sample(pick_sample(), 1'b0, '0);
    end

    drain();
    if (failures == 0)
      $display("PASS color_ramp_interpolator");
    else
      $display("FAIL color_ramp_interpolator");
    $finish;
  end

  initial begin : result_sink
    int k;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady_feed || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        k = idle_gap();
        out_stall <= (k != 0);
        repeat ((k == 0) ? 1 : k) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with no sample waiting: %h %h %h", out_red, out_green, out_blue);
        failures++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_red);
          failures++;
        end
        if (out_green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_green);
          failures++;
        end
        if (out_blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_blue);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG) begin
      $display("FAIL color_ramp_interpolator");
      $finish;
    end
  end

endmodule
